[rtl/svpes_pkg.sv]
package svpes_pkg;

    localparam int CNT_W  = 4;
    localparam int TIME_W = 12;
    localparam int MASK_W = 8;
    localparam int SEL_W  = 3;
    localparam int CMD_W  = 3;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BEGIN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COMPARE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd4;

    localparam logic [15:0] WIDTH_MIN = 16'd500;
    localparam logic [15:0] WIDTH_MAX = 16'd2500;

    typedef struct packed {
        logic             start;
        logic             build_step;
        logic             build_last;
        logic [SEL_W-1:0] build_idx;
    } ctrl_t;

    typedef struct packed {
        logic build_fail;
    } stat_t;

    typedef struct packed {
        logic [TIME_W-1:0] compare_at_us;
        logic              compare_armed;
        logic              compare_update;
        logic [MASK_W-1:0] pins_set_low;
        logic [MASK_W-1:0] pins_set_high;
        logic [3:0]        bad_servo;
        logic              status;
    } res_t;

endpackage

[rtl/svpes_ctrl.sv]
module svpes_ctrl
    import svpes_pkg::*;
#(
    parameter int SERVO_COUNT = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [CMD_W-1:0] command,
    input  logic             out_ready,
    input  stat_t            stat,
    output logic             in_ready,
    output logic             out_valid,
    output ctrl_t            ctrl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUILD = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    localparam logic [SEL_W-1:0] LAST_IDX = SEL_W'(SERVO_COUNT - 1);

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [SEL_W-1:0] idx_reg;
    logic [SEL_W-1:0] idx_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    assign ctrl.start      = in_valid && in_ready;
    assign ctrl.build_step = (state_reg == ST_BUILD);
    assign ctrl.build_last = (idx_reg == LAST_IDX);
    assign ctrl.build_idx  = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    idx_next   = '0;
                    state_next = (command == CMD_BUILD) ? ST_BUILD : ST_OUT;
                end
            end
            ST_BUILD:
            begin
                if (stat.build_fail || ctrl.build_last)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + SEL_W'(1);
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[rtl/svpes_datapath.sv]
module svpes_datapath
    import svpes_pkg::*;
#(
    parameter int SERVO_COUNT = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    input  logic [CMD_W-1:0] command,
    input  logic [SEL_W-1:0] servo_index,
    input  logic [15:0]      req_width,
    output stat_t            stat,
    output res_t             result
);

    localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
    localparam logic [MASK_W-1:0] ALL_PINS  = MASK_W'((1 << SERVO_COUNT) - 1);
    localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(SERVO_COUNT);

    logic [15:0]       staged_width_reg [SERVO_COUNT];
    logic [TIME_W-1:0] staged_time_reg  [SERVO_COUNT];
    logic [MASK_W-1:0] staged_mask_reg  [SERVO_COUNT];
    logic [CNT_W-1:0]  staged_count_reg;
    logic [TIME_W-1:0] active_time_reg  [SERVO_COUNT];
    logic [MASK_W-1:0] active_mask_reg  [SERVO_COUNT];
    logic [CNT_W-1:0]  active_count_reg;
    logic [CNT_W-1:0]  next_edge_reg;
    logic [TIME_W-1:0] work_time_reg    [SERVO_COUNT];
    logic [MASK_W-1:0] work_mask_reg    [SERVO_COUNT];
    logic [CNT_W-1:0]  work_count_reg;
    res_t              result_reg;

    logic [TIME_W-1:0] work_time_next   [SERVO_COUNT];
    logic [MASK_W-1:0] work_mask_next   [SERVO_COUNT];
    logic [CNT_W-1:0]  work_count_next;

    logic [IDX_W-1:0]  bidx;
    logic [15:0]       cur_width;
    logic              width_bad;
    logic [TIME_W-1:0] cur_at;
    logic [MASK_W-1:0] cur_pin;
    logic [CNT_W-1:0]  ins_pos;
    logic              hit;
    logic [CNT_W-1:0]  next_edge_inc;
    logic              edge_left;
    logic              edge_more;
    res_t              res_exec;
    res_t              res_fail;

    assign bidx      = ctrl.build_idx[IDX_W-1:0];
    assign cur_width = staged_width_reg[bidx];
    assign width_bad = (cur_width < WIDTH_MIN) || (cur_width > WIDTH_MAX);
    assign cur_at    = cur_width[TIME_W-1:0];
    assign cur_pin   = MASK_W'(1) << bidx;

    assign stat.build_fail = ctrl.build_step && width_bad;
    assign result          = result_reg;

    // The working list is kept sorted, so the number of earlier edges is the insert place.
    always_comb
    begin
        ins_pos = '0;
        hit     = 1'b0;
        for (int k = 0; k < SERVO_COUNT; k++)
        begin
            if (CNT_W'(k) < work_count_reg)
            begin
                if (work_time_reg[k] < cur_at)
                begin
                    ins_pos = ins_pos + CNT_W'(1);
                end
                if (work_time_reg[k] == cur_at)
                begin
                    hit = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < SERVO_COUNT; k++)
        begin
            work_time_next[k] = work_time_reg[k];
            work_mask_next[k] = work_mask_reg[k];
        end
        if (hit)
        begin
            for (int k = 0; k < SERVO_COUNT; k++)
            begin
                if (CNT_W'(k) == ins_pos)
                begin
                    work_mask_next[k] = work_mask_reg[k] | cur_pin;
                end
            end
            work_count_next = work_count_reg;
        end
        else
        begin
            if (ins_pos == '0)
            begin
                work_time_next[0] = cur_at;
                work_mask_next[0] = cur_pin;
            end
            for (int k = 1; k < SERVO_COUNT; k++)
            begin
                if (CNT_W'(k) == ins_pos)
                begin
                    work_time_next[k] = cur_at;
                    work_mask_next[k] = cur_pin;
                end
                else if (CNT_W'(k) > ins_pos)
                begin
                    work_time_next[k] = work_time_reg[k-1];
                    work_mask_next[k] = work_mask_reg[k-1];
                end
            end
            work_count_next = work_count_reg + CNT_W'(1);
        end
    end

    assign next_edge_inc = next_edge_reg + CNT_W'(1);
    assign edge_left     = (next_edge_reg < active_count_reg);
    assign edge_more     = (next_edge_inc < active_count_reg);

    always_comb
    begin
        res_exec = '0;
        unique case (command)
            CMD_BEGIN:
            begin
                res_exec.pins_set_high  = ALL_PINS;
                res_exec.compare_update = 1'b1;
                if (staged_count_reg != '0)
                begin
                    res_exec.compare_armed = 1'b1;
                    res_exec.compare_at_us = staged_time_reg[0];
                end
            end
            CMD_COMPARE:
            begin
                res_exec.compare_update = 1'b1;
                if (edge_left)
                begin
                    res_exec.pins_set_low =
                        active_mask_reg[next_edge_reg[IDX_W-1:0]] & ALL_PINS;
                    if (edge_more)
                    begin
                        res_exec.compare_armed = 1'b1;
                        res_exec.compare_at_us = active_time_reg[next_edge_inc[IDX_W-1:0]];
                    end
                end
            end
            CMD_STOP:
            begin
                res_exec.pins_set_low   = ALL_PINS;
                res_exec.compare_update = 1'b1;
            end
            default:
            begin
                res_exec = '0;
            end
        endcase
    end

    always_comb
    begin
        res_fail           = '0;
        res_fail.status    = 1'b1;
        res_fail.bad_servo = 4'(ctrl.build_idx) + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SERVO_COUNT; k++)
            begin
                staged_width_reg[k] <= '0;
            end
            staged_count_reg <= '0;
            active_count_reg <= '0;
            next_edge_reg    <= '0;
            work_count_reg   <= '0;
        end
        else
        begin
            if (ctrl.start)
            begin
                case (command)
                    CMD_LOAD:
                    begin
                        if ({1'b0, servo_index} < COUNT_MAX)
                        begin
                            staged_width_reg[servo_index[IDX_W-1:0]] <= req_width;
                        end
                    end
                    CMD_BUILD:
                    begin
                        work_count_reg <= '0;
                    end
                    CMD_BEGIN:
                    begin
                        active_count_reg <= staged_count_reg;
                        next_edge_reg    <= '0;
                    end
                    CMD_COMPARE:
                    begin
                        if (edge_left)
                        begin
                            next_edge_reg <= next_edge_inc;
                        end
                    end
                    CMD_STOP:
                    begin
                        next_edge_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctrl.build_step && !width_bad)
            begin
                work_count_reg <= work_count_next;
                if (ctrl.build_last)
                begin
                    staged_count_reg <= work_count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start && (command == CMD_BEGIN))
        begin
            for (int k = 0; k < SERVO_COUNT; k++)
            begin
                active_time_reg[k] <= staged_time_reg[k];
                active_mask_reg[k] <= staged_mask_reg[k];
            end
        end
        if (ctrl.start && (command != CMD_BUILD))
        begin
            result_reg <= res_exec;
        end
        if (ctrl.build_step)
        begin
            if (width_bad)
            begin
                result_reg <= res_fail;
            end
            else
            begin
                for (int k = 0; k < SERVO_COUNT; k++)
                begin
                    work_time_reg[k] <= work_time_next[k];
                    work_mask_reg[k] <= work_mask_next[k];
                end
                if (ctrl.build_last)
                begin
                    for (int k = 0; k < SERVO_COUNT; k++)
                    begin
                        staged_time_reg[k] <= work_time_next[k];
                        staged_mask_reg[k] <= work_mask_next[k];
                    end
                    result_reg <= '0;
                end
            end
        end
    end

endmodule

[rtl/servo_pulse_edge_scheduler.sv]
// Servo pulse edge scheduler. Each item carries a command in s_axis_tuser and gives exactly
// one result item. Load, begin frame, compare event, stop and unused codes produce their
// result in the cycle after acceptance; a build walks the servos one per cycle through a single
// insertion unit that places each width into the sorted edge list and stops early at the
// first out-of-range width. The block holds one item at a time: s_axis_tready is high only
// when no result is pending, and a result stays until m_axis_tready takes it. After a
// successful build the new plan becomes active at the next begin frame; a failed build
// leaves it as is.
module servo_pulse_edge_scheduler
    import svpes_pkg::*;
#(
    parameter int SERVO_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // servo_index, req_width
    input  logic [2:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status, bad_servo, pins_set_high, pins_set_low,
                                        // compare_update, compare_armed, compare_at_us
);

    ctrl_t ctrl;
    stat_t stat;
    res_t  result;

    svpes_ctrl #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .command   (s_axis_tuser),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .ctrl      (ctrl)
    );

    svpes_datapath #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .command     (s_axis_tuser),
        .servo_index (s_axis_tdata[2:0]),
        .req_width   (s_axis_tdata[18:3]),
        .stat        (stat),
        .result      (result)
    );

    assign m_axis_tdata = {5'd0, result};

endmodule

[rtl/svpes_checker.sv]
module svpes_checker
    import svpes_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // The block never takes a new item while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_BUILD) |=> m_axis_tvalid)
        else $error("single-step command gave no result in the next cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[39:5] == '0))
        else $error("failed build drove pins or the compare");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tdata[21])
        else $error("compare armed without an update");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind servo_pulse_edge_scheduler svpes_checker u_svpes_checker (.*);

[tb/testbench.sv]
module testbench;
    import svpes_pkg::*;

    localparam int SERVOS = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    logic [15:0] width_stage [SERVOS];
    logic [11:0] plan_time [SERVOS];
    logic [7:0]  plan_mask [SERVOS];
    int          plan_len;
    logic [11:0] live_time [SERVOS];
    logic [7:0]  live_mask [SERVOS];
    int          live_len;
    int          edge_ptr;

    res_t        predicted_outputs [$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_len = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          failed = 1'b0;

    servo_pulse_edge_scheduler uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("servo_pulse_edge_scheduler: mismatch");
            $finish;
        end
    end

    function automatic res_t schedule_step(logic [2:0] cmd, logic [2:0] idx, logic [15:0] w);
        res_t        r;
        logic [11:0] t [SERVOS];
        logic [7:0]  m [SERVOS];
        int          n;
        int          s;
        int          e;
        int          k;
        bit          bad;
        r = '0;
        bad = 1'b0;
        n = 0;
        case (cmd)
            CMD_LOAD:
                width_stage[idx] = w;
            CMD_BUILD:
            begin
                for (s = 0; s < SERVOS && !bad; s++)
                begin
                    if (width_stage[s] < WIDTH_MIN || width_stage[s] > WIDTH_MAX)
                    begin
                        bad = 1'b1;
                        r.status = 1'b1;
                        r.bad_servo = 4'(s + 1);
                    end
                end
                if (!bad)
                begin
                    for (s = 0; s < SERVOS; s++)
                    begin
                        e = 0;
                        while (e < n && t[e] < width_stage[s][11:0])
                            e++;
                        if (e < n && t[e] == width_stage[s][11:0])
                            m[e] = m[e] | 8'(1 << s);
                        else
                        begin
                            for (k = n; k > e; k--)
                            begin
                                t[k] = t[k-1];
                                m[k] = m[k-1];
                            end
                            t[e] = width_stage[s][11:0];
                            m[e] = 8'(1 << s);
                            n++;
                        end
                    end
                    for (k = 0; k < n; k++)
                    begin
                        plan_time[k] = t[k];
                        plan_mask[k] = m[k];
                    end
                    plan_len = n;
                end
            end
            CMD_BEGIN:
            begin
                live_time = plan_time;
                live_mask = plan_mask;
                live_len = plan_len;
                edge_ptr = 0;
                r.pins_set_high = 8'hFF;
                r.compare_update = 1'b1;
                if (live_len != 0)
                begin
                    r.compare_armed = 1'b1;
                    r.compare_at_us = live_time[0];
                end
            end
            CMD_COMPARE:
            begin
                r.compare_update = 1'b1;
                if (edge_ptr < live_len)
                begin
                    r.pins_set_low = live_mask[edge_ptr];
                    edge_ptr++;
                    if (edge_ptr < live_len)
                    begin
                        r.compare_armed = 1'b1;
                        r.compare_at_us = live_time[edge_ptr];
                    end
                end
            end
            CMD_STOP:
            begin
                r.pins_set_low = 8'hFF;
                r.compare_update = 1'b1;
                edge_ptr = 0;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic send_item(logic [2:0] cmd, logic [2:0] idx, logic [15:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, w, idx};
        s_axis_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted_outputs.push_back(schedule_step(cmd, idx, w));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic compare_field(string name, int expected_val, int actual_val);
        if (expected_val != actual_val)
        begin
            $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = res_t'(m_axis_tdata[34:0]);
            if (predicted_outputs.size() == 0)
            begin
                $error("result item arrived with nothing outstanding");
                failed = 1'b1;
            end
            else
            begin
                want = predicted_outputs.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("bad_servo", want.bad_servo, got.bad_servo);
                compare_field("pins_set_high", want.pins_set_high, got.pins_set_high);
                compare_field("pins_set_low", want.pins_set_low, got.pins_set_low);
                compare_field("compare_update", want.compare_update, got.compare_update);
                compare_field("compare_armed", want.compare_armed, got.compare_armed);
                compare_field("compare_at_us", want.compare_at_us, got.compare_at_us);
            end
        end
    end

    task automatic test_directed();
        int s;
        send_item(CMD_BUILD, 3'd0, 16'd0);
        send_item(CMD_BEGIN, 3'd0, 16'd0);
        send_item(CMD_COMPARE, 3'd0, 16'd0);
        send_item(CMD_STOP, 3'd0, 16'd0);
        send_item(CMD_SPARE_LO, 3'd7, 16'hFFFF);
        send_item(CMD_SPARE_HI, 3'd0, 16'd0);
        for (s = 0; s < SERVOS; s++)
            send_item(CMD_LOAD, 3'(s), 16'd1500);
        send_item(CMD_BUILD, 3'd0, 16'd0);
        send_item(CMD_BEGIN, 3'd0, 16'd0);
        send_item(CMD_COMPARE, 3'd0, 16'd0);
        send_item(CMD_COMPARE, 3'd0, 16'd0);
        send_item(CMD_LOAD, 3'd7, 16'hFFFF);
        send_item(CMD_BUILD, 3'd0, 16'd0);
        send_item(CMD_LOAD, 3'd3, 16'd499);
        send_item(CMD_BUILD, 3'd0, 16'd0);
        send_item(CMD_LOAD, 3'd3, 16'd2501);
        send_item(CMD_BUILD, 3'd0, 16'd0);
        send_item(CMD_LOAD, 3'd3, 16'd500);
        send_item(CMD_LOAD, 3'd7, 16'd2500);
        send_item(CMD_BUILD, 3'd0, 16'd0);
        send_item(CMD_BEGIN, 3'd0, 16'd0);
        for (s = 0; s < 4; s++)
            send_item(CMD_COMPARE, 3'd0, 16'd0);
        wait_drained();
    endtask

    task automatic send_frame_or_noise();
        int          s;
        int          edges;
        logic [15:0] w;
        if ($urandom_range(0, 99) < 75)
        begin
            for (s = 0; s < SERVOS; s++)
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: w = 16'(500 * $urandom_range(1, 5));
                        3:       w = ($urandom_range(0, 1) != 0) ? 16'(
                                     $urandom_range(0, 499)) : 16'($urandom_range(2501, 65535));
                        default: w = 16'($urandom_range(500, 2500));
                    endcase
                    send_item(CMD_LOAD, 3'(s), w);
                end
            end
            send_item(CMD_BUILD, 3'($urandom), 16'($urandom));
            send_item(CMD_BEGIN, 3'($urandom), 16'($urandom));
            edges = $urandom_range(0, 9);
            for (s = 0; s < edges; s++)
                send_item(CMD_COMPARE, 3'($urandom), 16'($urandom));
            if ($urandom_range(0, 2) == 0)
                send_item(CMD_STOP, 3'($urandom), 16'($urandom));
        end
        else
            send_item(3'($urandom_range(0, 7)), 3'($urandom), 16'($urandom));
    endtask

    task automatic test_stream(int idle_pct, int stall_pct, int count);
        int first;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        first = items_sent;
        while (items_sent - first < count)
            send_frame_or_noise();
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 300;
        send_frame_or_noise();
        send_frame_or_noise();
        wait_drained();
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 21;
        recv_stall_pct = 21;
        send_frame_or_noise();
        wait_drained();
        repeat (5) @(posedge clk);
        send_frame_or_noise();
        wait_drained();
    endtask

    initial
    begin
        int s;
        for (s = 0; s < SERVOS; s++)
            width_stage[s] = '0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_stream(0, 0, 250);
        test_stream(79, 0, 250);
        test_stream(0, 79, 250);
        test_stream(21, 21, 250);
        test_backpressure();
        test_sender_pause();
        repeat (20) @(posedge clk);
        if (!failed)
            $display("servo_pulse_edge_scheduler: match");
        else
            $display("servo_pulse_edge_scheduler: mismatch");
        $finish;
    end
endmodule
